/* src/dcm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Duty-cycle meter package
// Shared constants, record types and the channel pin selection function.
// ----------------------------------------------------------------------------
package dcm_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int TICK_BITS    = 17;
    localparam int LIMIT_BITS   = 16;
    localparam int CH_BITS      = 2;
    localparam int PINS_BITS    = 2;
    localparam int SHARE_BITS   = 7;
    localparam int QUEUE_DEPTH  = 2;   // power of two

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [SHARE_BITS-1:0] PERCENT     = 7'd100;

    localparam int REM_BITS = TICK_BITS + SHARE_BITS;
    localparam int PER_BITS = TICK_BITS + 1;
    localparam int IN_BITS  = 8;
    localparam int OUT_BITS = 56;

    localparam logic [CH_BITS-1:0] CH_A = 2'd0;
    localparam logic [CH_BITS-1:0] CH_B = 2'd1;
    localparam logic [CH_BITS-1:0] CH_C = 2'd2;
    localparam logic [CH_BITS-1:0] CH_D = 2'd3;

    // One finished measurement, handed from the sampler to the divider.
    typedef struct packed {
        logic [TICK_BITS-1:0] high_ticks;
        logic [TICK_BITS-1:0] low_ticks;
        logic                 failed;
        logic [CH_BITS-1:0]   channel;
    } t_meas;

    // One result as presented on the output stream.
    typedef struct packed {
        logic [TICK_BITS-1:0]  high_ticks;
        logic [TICK_BITS-1:0]  low_ticks;
        logic [SHARE_BITS-1:0] high_share;
        logic [SHARE_BITS-1:0] low_share;
        logic                  failed;
        logic [CH_BITS-1:0]    channel;
    } t_result;

    // Level of the selected encoder channel in the current sample.
    function automatic logic pin_level(input logic [CH_BITS-1:0]   ch,
                                       input logic [PINS_BITS-1:0] right,
                                       input logic [PINS_BITS-1:0] left);
        logic lvl;
        unique case (ch)
            CH_A:    lvl = right[0];
            CH_B:    lvl = right[1];
            CH_C:    lvl = left[1];
            default: lvl = left[0];
        endcase
        return lvl;
    endfunction

endpackage
`default_nettype wire

/* src/dcm_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Duty-cycle meter sampler
// Takes one pin sample per transaction, tracks the measurement phase and
// pushes a finished measurement record into the queue.
// ----------------------------------------------------------------------------
module dcm_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [dcm_pkg::LIMIT_BITS-1:0] i_cfg_wr_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_start_req,
    input  wire logic [dcm_pkg::CH_BITS-1:0]   i_channel,
    input  wire logic [dcm_pkg::PINS_BITS-1:0] i_right_pins,
    input  wire logic [dcm_pkg::PINS_BITS-1:0] i_left_pins,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output dcm_pkg::t_meas                     o_push_data
);
    import dcm_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_LOW, PH_WAIT_RISE, PH_COUNT_HIGH, PH_COUNT_LOW
    } t_phase;

    t_phase                r_phase, n_phase, eff_phase;
    logic [CH_BITS-1:0]    r_channel, eff_channel;
    logic [TICK_BITS-1:0]  r_timer, n_timer, eff_timer;
    logic [TICK_BITS-1:0]  r_high, n_high, eff_high;
    logic [TICK_BITS-1:0]  r_low, n_low, eff_low;
    logic [LIMIT_BITS-1:0] r_limit;

    logic                 fire, starting, lvl, fail, done, one_fail;
    logic [TICK_BITS:0]   limit_ext, timer_inc, high_inc, low_inc;
    logic                 timer_fail, high_fail, low_fail;

    assign o_ready = !i_q_full;
    assign fire    = i_valid && o_ready;

    always_comb begin
        starting = (r_phase == PH_IDLE) && i_start_req
                   && ({1'b0, i_channel} < (CH_BITS+1)'(NUM_CHANNELS));
        if (r_phase == PH_IDLE) begin
            eff_phase   = starting ? PH_WAIT_LOW : PH_IDLE;
            eff_channel = i_channel;
            eff_timer   = '0;
            eff_high    = '0;
            eff_low     = '0;
        end else begin
            eff_phase   = r_phase;
            eff_channel = r_channel;
            eff_timer   = r_timer;
            eff_high    = r_high;
            eff_low     = r_low;
        end
        lvl = pin_level(eff_channel, i_right_pins, i_left_pins);

        // A counter fails past the limit or when it would leave its range.
        limit_ext  = (TICK_BITS+1)'(r_limit);
        one_fail   = (r_limit == '0);
        timer_inc  = {1'b0, eff_timer} + 1'b1;
        high_inc   = {1'b0, eff_high} + 1'b1;
        low_inc    = {1'b0, eff_low} + 1'b1;
        timer_fail = (&eff_timer) || (timer_inc > limit_ext);
        high_fail  = (&eff_high) || (high_inc > limit_ext);
        low_fail   = (&eff_low) || (low_inc > limit_ext);

        n_phase = eff_phase;
        n_timer = eff_timer;
        n_high  = eff_high;
        n_low   = eff_low;
        fail    = 1'b0;
        done    = 1'b0;
        unique case (eff_phase)
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            PH_WAIT_LOW: begin
                if (!lvl) begin
                    n_phase = PH_WAIT_RISE;
                    n_timer = TICK_BITS'(1);
                    fail    = one_fail;
                end else begin
                    n_timer = timer_inc[TICK_BITS-1:0];
                    fail    = timer_fail;
                end
            end
            PH_WAIT_RISE: begin
                if (lvl) begin
                    n_phase = PH_COUNT_HIGH;
                    n_timer = '0;
                    n_high  = TICK_BITS'(1);
                    fail    = one_fail;
                end else begin
                    n_timer = timer_inc[TICK_BITS-1:0];
                    fail    = timer_fail;
                end
            end
            PH_COUNT_HIGH: begin
                if (!lvl) begin
                    n_phase = PH_COUNT_LOW;
                    n_low   = TICK_BITS'(1);
                    fail    = one_fail;
                end else begin
                    n_high = high_inc[TICK_BITS-1:0];
                    fail   = high_fail;
                end
            end
            PH_COUNT_LOW: begin
                if (lvl) begin
                    done = 1'b1;
                end else begin
                    n_low = low_inc[TICK_BITS-1:0];
                    fail  = low_fail;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (fail || done) begin
            n_phase = PH_IDLE;
            n_timer = '0;
        end

        o_push                  = fire && (fail || done);
        o_push_data.high_ticks  = fail ? '0 : eff_high;
        o_push_data.low_ticks   = fail ? '0 : eff_low;
        o_push_data.failed      = fail;
        o_push_data.channel     = eff_channel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_channel <= '0;
            r_timer   <= '0;
            r_high    <= '0;
            r_low     <= '0;
            r_limit   <= LIMIT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (fire) begin
                r_phase   <= n_phase;
                r_channel <= eff_channel;
                r_timer   <= n_timer;
                r_high    <= n_high;
                r_low     <= n_low;
            end
        end
    end

endmodule
`default_nettype wire

/* src/dcm_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Duty-cycle meter record queue
// Small FIFO of finished measurements between the sampler and the divider.
// ----------------------------------------------------------------------------
module dcm_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dcm_pkg::t_meas  i_push_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output dcm_pkg::t_meas       o_data
);
    import dcm_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_meas               r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_BITS:0]   r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* src/dcm_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Duty-cycle meter share divider
// Restoring divider that produces both percentage shares one quotient bit
// per cycle, followed by the output register.
// ----------------------------------------------------------------------------
module dcm_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire dcm_pkg::t_meas  i_meas,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output dcm_pkg::t_result     o_result
);
    import dcm_pkg::*;

    localparam int STEP_BITS = $clog2(SHARE_BITS);

    logic                  r_busy, r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic [REM_BITS-1:0]   r_rem_hi, r_rem_lo;
    logic [PER_BITS-1:0]   r_per;
    logic [SHARE_BITS-1:0] r_q_hi, r_q_lo;
    t_meas                 r_meas;
    logic                  r_out_valid;
    t_result               r_out;

    logic [REM_BITS-1:0]   trial;
    logic                  ge_hi, ge_lo, load, unload;

    assign o_ready = !r_busy;
    assign load    = i_valid && !r_busy;
    assign unload  = r_done && (!r_out_valid || i_ready);
    assign trial   = REM_BITS'(r_per) << r_step;
    assign ge_hi   = (r_rem_hi >= trial);
    assign ge_lo   = (r_rem_lo >= trial);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_meas   <= i_meas;
            r_per    <= {1'b0, i_meas.high_ticks} + {1'b0, i_meas.low_ticks};
            r_rem_hi <= REM_BITS'(i_meas.high_ticks) * REM_BITS'(PERCENT);
            r_rem_lo <= REM_BITS'(i_meas.low_ticks) * REM_BITS'(PERCENT);
            r_q_hi   <= '0;
            r_q_lo   <= '0;
            r_step   <= STEP_BITS'(SHARE_BITS - 1);
        end else if (r_busy && !r_done) begin
            if (ge_hi) begin
                r_rem_hi <= r_rem_hi - trial;
            end
            if (ge_lo) begin
                r_rem_lo <= r_rem_lo - trial;
            end
            r_q_hi <= {r_q_hi[SHARE_BITS-2:0], ge_hi};
            r_q_lo <= {r_q_lo[SHARE_BITS-2:0], ge_lo};
            r_step <= r_step - 1'b1;
        end
        if (unload) begin
            r_out.high_ticks <= r_meas.high_ticks;
            r_out.low_ticks  <= r_meas.low_ticks;
            r_out.high_share <= r_meas.failed ? '0 : r_q_hi;
            r_out.low_share  <= r_meas.failed ? '0 : r_q_lo;
            r_out.failed     <= r_meas.failed;
            r_out.channel    <= r_meas.channel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (unload) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
            end else if (r_busy && (r_step == '0)) begin
                r_done <= 1'b1;
            end
            if (unload) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* src/duty_cycle_meter_with_timeout.sv */
// Result path: the sample that ends a measurement is followed by the divider
//   load, 7 divider steps and the output register.
// Throughput: one sample per cycle while the record queue has room; the
//   share divider takes a new measurement only once the last has been unloaded.
// Reset: synchronous, active low; clears the phase machine, queue and output
//   and sets the timeout limit to 65535.
`default_nettype none
// ----------------------------------------------------------------------------
// Duty-cycle meter with timeout
// Measures high and low time of one encoder channel over one full period
// and reports both tick counts and their percentage shares.
// ----------------------------------------------------------------------------
module duty_cycle_meter_with_timeout (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Timeout register, written whenever the enable is high.
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [dcm_pkg::LIMIT_BITS-1:0] i_cfg_wr_data,
    // Sample stream.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] start_req, [2:1] channel, [4:3] right_pins, [6:5] left_pins, [7] zero
    input  wire logic [dcm_pkg::IN_BITS-1:0]    s_axis_tdata,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [16:0] high_ticks, [33:17] low_ticks, [40:34] high_share,
    // [47:41] low_share, [48] failed, [50:49] measured_channel, [55:51] zero
    output logic [dcm_pkg::OUT_BITS-1:0]        m_axis_tdata
);
    import dcm_pkg::*;

    // The sampler runs the phase machine at the sample rate. Every sample
    // that ends a measurement (success or timeout) produces one record,
    // which waits in the queue until the divider is free. The sampler only
    // stalls when the queue is full, so the divider and the output side can
    // back up without losing a record.
    logic    push, q_full, q_valid, q_pop;
    t_meas   push_data, q_data;
    t_result result;

    dcm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_start_req   (s_axis_tdata[0]),
        .i_channel     (s_axis_tdata[2:1]),
        .i_right_pins  (s_axis_tdata[4:3]),
        .i_left_pins   (s_axis_tdata[6:5]),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    dcm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    // The divider takes a record whenever it is idle; its output register
    // lets it start the next division while a result still waits.
    dcm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_pop),
        .i_meas   (q_data),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // Fields are packed from the lowest bit up, the unused top bits zero.
    assign m_axis_tdata = {5'b0, result.channel, result.failed, result.low_share,
                           result.high_share, result.low_ticks, result.high_ticks};

    // A failed measurement carries only zeros.
    a_fail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && result.failed) |->
        (result.high_ticks == '0) && (result.low_ticks == '0)
        && (result.high_share == '0) && (result.low_share == '0))
        else $error("failed result with nonzero values");

    // A good measurement has both phases and shares that add up to 99 or 100.
    a_good_shares : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !result.failed) |->
        (result.high_ticks != '0) && (result.low_ticks != '0)
        && (({1'b0, result.high_share} + {1'b0, result.low_share}) == 8'd100
            || ({1'b0, result.high_share} + {1'b0, result.low_share}) == 8'd99))
        else $error("shares of a good result out of range");

    // A record is only written while the queue has a free slot.
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("record pushed into a full queue");

endmodule
`default_nettype wire

/* tb/tb_duty_cycle_meter_with_timeout.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Duty-cycle meter testbench
// Streams encoder pin samples into the meter, predicts every measurement in
// step with the accepted sample transactions and checks each result
// transaction against the oldest prediction, under random idling on both
// sides, one long output stall and a sweep of timeout limits.
// ----------------------------------------------------------------------------
module tb_duty_cycle_meter_with_timeout;
    import dcm_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_PCT      = 31;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int NUM_PHASES    = 8;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 30;
    localparam int HOLD_CYCLES   = 600;
    localparam int SHOW_FAULTS   = 10;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    localparam logic [TICK_BITS-1:0]  TICK_CEIL = '1;
    localparam logic [LIMIT_BITS-1:0] LIM_ONE   = 16'd1;

    // Phases of one measurement, as the predictor tracks them.
    typedef enum logic [2:0] {
        MTR_IDLE,
        MTR_WAIT_LOW,
        MTR_WAIT_RISE,
        MTR_COUNT_HIGH,
        MTR_COUNT_LOW
    } meter_phase_e;

    // One row of the directed stimulus table. Rows marked typed carry the
    // result that the sample is known to close; the others rely on the
    // predictor.
    typedef struct {
        logic [LIMIT_BITS-1:0] lim;
        logic [IN_BITS-1:0]    sample;
        bit                    typed;
        t_result               res;
    } sample_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [LIMIT_BITS-1:0] i_cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_BITS-1:0]    s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_BITS-1:0]   m_axis_tdata;

    // Predictor state: a private copy of the meter's phase machine and limit.
    meter_phase_e          mtr_phase;
    logic [CH_BITS-1:0]    mtr_channel;
    logic [TICK_BITS-1:0]  mtr_timer;
    logic [TICK_BITS-1:0]  mtr_high;
    logic [TICK_BITS-1:0]  mtr_low;
    logic [LIMIT_BITS-1:0] mtr_limit;

    // Measurements predicted but not yet seen on the result stream.
    t_result     meter_results[$];
    sample_row_t sample_table[$];

    int unsigned fault_count;
    int unsigned items_sent;
    // Calm turns off idling on both sides; hold_req asks the receiver for
    // its one long stall.
    logic        calm;
    logic        hold_req;

    duty_cycle_meter_with_timeout u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [0] start_req, [2:1] channel, [4:3] right_pins, [6:5] left_pins, [7] zero
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [16:0] high_ticks, [33:17] low_ticks, [40:34] high_share,
        // [47:41] low_share, [48] failed, [50:49] measured_channel, [55:51] zero
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Advance a phase counter by one sample. Returns 1 when the phase has
    // now run longer than the limit or would leave the counter range.
    function automatic bit bump_tick(input logic [TICK_BITS-1:0] cnt,
                                     output logic [TICK_BITS-1:0] nxt);
        logic [TICK_BITS:0] n;
        n = {1'b0, cnt} + 1'b1;
        if (n > {1'b0, TICK_CEIL}) begin
            nxt = TICK_CEIL;
            return 1'b1;
        end
        nxt = n[TICK_BITS-1:0];
        return n > {{(TICK_BITS + 1 - LIMIT_BITS){1'b0}}, mtr_limit};
    endfunction

    // Build the result of the running measurement and return to idle. A
    // failed measurement reports all counts and shares as zero.
    task automatic close_measurement(input bit fail, output t_result r);
        int unsigned hi;
        int unsigned lo;
        int unsigned period;
        hi = fail ? 0 : mtr_high;
        lo = fail ? 0 : mtr_low;
        period = hi + lo;
        r.high_ticks = TICK_BITS'(hi);
        r.low_ticks  = TICK_BITS'(lo);
        r.high_share = (period == 0) ? '0 : SHARE_BITS'((hi * 100) / period);
        r.low_share  = (period == 0) ? '0 : SHARE_BITS'((lo * 100) / period);
        r.failed     = fail;
        r.channel    = mtr_channel;
        mtr_phase    = MTR_IDLE;
        mtr_timer    = '0;
    endtask

    // Feed one accepted sample to the predictor.
    task automatic step_meter(input logic [IN_BITS-1:0] d, output bit produced,
                              output t_result r);
        logic [3:0] levels;
        logic       lvl;
        bit         over;
        bit         active;
        produced = 1'b0;
        r        = '0;
        over     = 1'b0;
        active   = 1'b1;
        // An idle meter only wakes on a start; that sample already belongs
        // to the wait-while-high phase.
        if (mtr_phase == MTR_IDLE) begin
            if (d[0]) begin
                mtr_channel = d[2:1];
                mtr_phase   = MTR_WAIT_LOW;
                mtr_timer   = '0;
                mtr_high    = '0;
                mtr_low     = '0;
            end else begin
                active = 1'b0;
            end
        end
        // Pin levels indexed by channel: A right[0], B right[1], C left[1],
        // D left[0].
        levels = {d[5], d[6], d[4], d[3]};
        lvl    = levels[mtr_channel];
        if (active) begin
            case (mtr_phase)
                MTR_WAIT_LOW: begin
                    if (!lvl) begin
                        mtr_phase = MTR_WAIT_RISE;
                        over = bump_tick('0, mtr_timer);
                    end else begin
                        over = bump_tick(mtr_timer, mtr_timer);
                    end
                end
                MTR_WAIT_RISE: begin
                    if (lvl) begin
                        // The edge sample is the first high sample.
                        mtr_phase = MTR_COUNT_HIGH;
                        mtr_timer = '0;
                        over = bump_tick('0, mtr_high);
                    end else begin
                        over = bump_tick(mtr_timer, mtr_timer);
                    end
                end
                MTR_COUNT_HIGH: begin
                    if (!lvl) begin
                        mtr_phase = MTR_COUNT_LOW;
                        over = bump_tick('0, mtr_low);
                    end else begin
                        over = bump_tick(mtr_high, mtr_high);
                    end
                end
                MTR_COUNT_LOW: begin
                    if (lvl) begin
                        close_measurement(1'b0, r);
                        produced = 1'b1;
                    end else begin
                        over = bump_tick(mtr_low, mtr_low);
                    end
                end
                default: begin
                    mtr_phase = MTR_IDLE;
                end
            endcase
        end
        if (over) begin
            close_measurement(1'b1, r);
            produced = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // A sample with the given level on the selected channel and random
    // levels on the three other pins.
    function automatic logic [IN_BITS-1:0] make_sample(input bit start,
                                                       input logic [CH_BITS-1:0] ch,
                                                       input bit lvl);
        logic [3:0] levels;
        levels     = 4'($urandom);
        levels[ch] = lvl;
        return {1'b0, levels[2], levels[3], levels[1], levels[0], ch, start};
    endfunction

    // Length of one segment of a generated waveform. Most fit the limit; a
    // few overrun the cap (a timeout if it is the limit), or run long if the limit is high.
    function automatic int seg_len(input int cap, input bit allow_zero);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12 && mtr_limit <= 300)
            return cap + $urandom_range(1, 3);
        if (pick < 12)
            return $urandom_range(41, 300);
        return $urandom_range(allow_zero ? 0 : 1, cap);
    endfunction

    // Offer one sample transaction and predict its effect once accepted.
    // The valid stays high on return so that the next call can follow
    // back to back; a gap lowers it first.
    task automatic send_sample(input logic [IN_BITS-1:0] d, input bit typed,
                               input t_result typed_res);
        bit      produced;
        t_result r;
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        step_meter(d, produced, r);
        if (typed)
            meter_results.push_back(typed_res);
        else if (produced)
            meter_results.push_back(r);
        items_sent++;
    endtask

    // Change the timeout limit with the meter idle: stop offering samples,
    // let every result out, allow the pipeline to settle, then write.
    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (meter_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mtr_limit = value;
    endtask

    task automatic add_row(input logic [LIMIT_BITS-1:0] lim, input bit start,
                           input logic [CH_BITS-1:0] ch,
                           input logic [PINS_BITS-1:0] right,
                           input logic [PINS_BITS-1:0] left, input bit typed,
                           input int hi, input int lo, input int hs,
                           input int ls, input bit fl);
        sample_row_t row;
        row.lim            = lim;
        row.sample         = {1'b0, left, right, ch, start};
        row.typed          = typed;
        row.res.high_ticks = TICK_BITS'(hi);
        row.res.low_ticks  = TICK_BITS'(lo);
        row.res.high_share = SHARE_BITS'(hs);
        row.res.low_share  = SHARE_BITS'(ls);
        row.res.failed     = fl;
        row.res.channel    = ch;
        sample_table.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver and checker
    // ------------------------------------------------------------------------
    // Every rising edge with valid and ready high is one result transaction;
    // it is unpacked and compared with the oldest predicted measurement.
    // Ready is chosen for the next cycle at random (always high while calm),
    // except during the one long hold-off that fills the meter and stalls its input.
    initial begin
        t_result got;
        t_result want;
        int      hold_left;
        bit      hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.high_ticks = m_axis_tdata[16:0];
                got.low_ticks  = m_axis_tdata[33:17];
                got.high_share = m_axis_tdata[40:34];
                got.low_share  = m_axis_tdata[47:41];
                got.failed     = m_axis_tdata[48];
                got.channel    = m_axis_tdata[50:49];
                if (meter_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= SHOW_FAULTS)
                        $display("%0t: unexpected result transaction hi=%0d lo=%0d",
                                 $realtime, got.high_ticks, got.low_ticks);
                end else begin
                    want = meter_results.pop_front();
                    if (got !== want) begin
                        fault_count++;
                        if (fault_count <= SHOW_FAULTS) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected hi=%0d lo=%0d hs=%0d ls=%0d fail=%0b ch=%0d",
                                     want.high_ticks, want.low_ticks, want.high_share,
                                     want.low_share, want.failed, want.channel);
                            $display("  actual   hi=%0d lo=%0d hs=%0d ls=%0d fail=%0b ch=%0d",
                                     got.high_ticks, got.low_ticks, got.high_share,
                                     got.low_share, got.failed, got.channel);
                        end
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [LIMIT_BITS-1:0] phase_limit [NUM_PHASES];
        logic [CH_BITS-1:0]    ch;
        int unsigned           phase_start;
        int unsigned           phase_goal;
        int                    cap;
        int                    len;
        int                    burst;
        bit                    first;
        bit                    lvl;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        fault_count   = 0;
        items_sent    = 0;

        // The predictor starts from the reset state of the meter.
        mtr_phase   = MTR_IDLE;
        mtr_channel = '0;
        mtr_timer   = '0;
        mtr_high    = '0;
        mtr_low     = '0;
        mtr_limit   = LIMIT_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Columns: limit, start, channel, right pins, left
        // pins, typed, then the typed result (high, low, shares, failed).
        // On typed rows the channel column names the measured channel; the
        // meter is busy there, so the field is ignored.
        //
        // Channel A with the reset limit: wait while high, rise, two high
        // samples (one carrying a start that must be ignored), one low.
        add_row(LIMIT_RESET, 1, CH_A, 2'b01, 2'b10, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b00, 2'b01, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b01, 2'b00, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 1, CH_D, 2'b11, 2'b11, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b10, 2'b00, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b01, 2'b00, 1, 2, 1, 66, 33, 0);
        // Channel B, start sample already low.
        add_row(LIMIT_RESET, 1, CH_B, 2'b01, 2'b11, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b10, 2'b00, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b01, 2'b00, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_B, 2'b11, 2'b00, 1, 1, 1, 50, 50, 0);
        // Channel C, one high and two low samples.
        add_row(LIMIT_RESET, 1, CH_C, 2'b11, 2'b01, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b00, 2'b10, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b11, 2'b01, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b11, 2'b00, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_C, 2'b00, 2'b11, 1, 1, 2, 33, 66, 0);
        // Channel D.
        add_row(LIMIT_RESET, 1, CH_D, 2'b00, 2'b10, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b00, 2'b01, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_A, 2'b11, 2'b10, 0, 0, 0, 0, 0, 0);
        add_row(LIMIT_RESET, 0, CH_D, 2'b00, 2'b11, 1, 1, 1, 50, 50, 0);
        // Limit of one sample: each phase in turn runs a sample too long.
        add_row(LIM_ONE, 1, CH_A, 2'b01, 2'b00, 0, 0, 0, 0, 0, 0);
        add_row(LIM_ONE, 0, CH_A, 2'b01, 2'b00, 1, 0, 0, 0, 0, 1);
        add_row(LIM_ONE, 1, CH_B, 2'b00, 2'b11, 0, 0, 0, 0, 0, 0);
        add_row(LIM_ONE, 0, CH_B, 2'b01, 2'b11, 1, 0, 0, 0, 0, 1);
        add_row(LIM_ONE, 1, CH_C, 2'b00, 2'b10, 0, 0, 0, 0, 0, 0);
        add_row(LIM_ONE, 0, CH_A, 2'b00, 2'b00, 0, 0, 0, 0, 0, 0);
        add_row(LIM_ONE, 0, CH_A, 2'b00, 2'b10, 0, 0, 0, 0, 0, 0);
        add_row(LIM_ONE, 0, CH_C, 2'b11, 2'b11, 1, 0, 0, 0, 0, 1);
        add_row(LIM_ONE, 1, CH_D, 2'b00, 2'b00, 0, 0, 0, 0, 0, 0);
        add_row(LIM_ONE, 0, CH_A, 2'b00, 2'b01, 0, 0, 0, 0, 0, 0);
        add_row(LIM_ONE, 0, CH_A, 2'b11, 2'b00, 0, 0, 0, 0, 0, 0);
        add_row(LIM_ONE, 0, CH_D, 2'b11, 2'b10, 1, 0, 0, 0, 0, 1);

        foreach (sample_table[i]) begin
            if (sample_table[i].lim != mtr_limit)
                write_limit(sample_table[i].lim);
            send_sample(sample_table[i].sample, sample_table[i].typed,
                        sample_table[i].res);
        end

        // Random part: a sweep of limits, the extremes among them. Phase 1
        // carries the long output stall, phase 3 runs without idling.
        phase_limit[0] = 16'd2;
        phase_limit[1] = 16'd5;
        phase_limit[2] = LIMIT_RESET;
        phase_limit[3] = LIMIT_BITS'($urandom_range(1, 30));
        phase_limit[4] = 16'd12;
        phase_limit[5] = LIMIT_BITS'($urandom_range(31, 300));
        phase_limit[6] = LIM_ONE;
        phase_limit[7] = LIMIT_RESET;
        phase_goal = RANDOM_ITEMS / NUM_PHASES;

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limit(phase_limit[p]);
            calm <= (p == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < phase_goal) begin
                if (p == 1 && items_sent - phase_start > 30)
                    hold_req <= 1'b1;
                if ($urandom_range(0, 99) < 20) begin
                    // Noise: fully random samples, stray starts included.
                    burst = $urandom_range(1, 6);
                    repeat (burst)
                        send_sample(8'($urandom) & 8'h7F, 1'b0, '0);
                end else begin
                    // A well-formed period with random segment lengths:
                    // high (possibly none), low, high, low, then the rise
                    // that closes it. Later samples carry an occasional
                    // start that the busy meter must ignore.
                    ch    = CH_BITS'($urandom_range(0, NUM_CHANNELS - 1));
                    cap   = (mtr_limit < 40) ? int'(mtr_limit) : 40;
                    first = 1'b1;
                    for (int k = 0; k < 4; k++) begin
                        len = seg_len(cap, k == 0);
                        lvl = (k % 2 == 0);
                        repeat (len) begin
                            send_sample(make_sample(first || ($urandom_range(0, 7) == 0),
                                                    ch, lvl), 1'b0, '0);
                            first = 1'b0;
                        end
                    end
                    send_sample(make_sample(first, ch, 1'b1), 1'b0, '0);
                end
            end
            // Walk any open measurement to its end so the limit can be
            // changed with the meter idle.
            while (mtr_phase != MTR_IDLE) begin
                lvl = (mtr_phase == MTR_WAIT_RISE) || (mtr_phase == MTR_COUNT_LOW);
                send_sample(make_sample(1'b0, mtr_channel, lvl), 1'b0, '0);
            end
        end
        calm <= 1'b0;

        // Drain: every prediction must come out, then a quiet tail catches
        // any result that should not exist.
        s_axis_tvalid <= 1'b0;
        while (meter_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
